// ===== rtl/core/cud_pkg.sv =====
// shared types, constants and tables for the cud quasi-random generator
package cud_pkg;

  // sequence shape
  localparam int STAGES        = 16;
  localparam int FRACTION_BITS = 32;

  // field widths
  localparam int MULT_W  = 31;
  localparam int STAGE_W = 4;
  localparam int FRAC_W  = 32;

  // log table: ln(p) for the first sixteen primes, unsigned Q3.61 in 64 bits
  localparam int ROM_DEPTH  = 16;
  localparam int ROM_IDX_W  = 4;
  localparam int ROM_W      = 64;
  localparam int LOG_FRAC   = 61;
  localparam int FRAC_SHIFT = LOG_FRAC - FRACTION_BITS;
  localparam int LO_W       = 32;
  localparam int HI_W       = LOG_FRAC - LO_W;
  localparam int PLO_W      = MULT_W + LO_W;

  // table builder: ln(n) accumulated in Q2.62 up to the last prime
  localparam int N_W      = 6;
  localparam int LAST_N   = 53;
  localparam int SLOT_W   = 5;
  localparam int K_W      = 5;
  localparam int Q_W      = 7;
  localparam int DEN_W    = 14;
  localparam int DIV_W    = 63;
  localparam int DIV_CNT_W = 6;
  localparam int ACC_W    = 64;

  // decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register map
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_START = 1'b0;

  typedef enum logic [2:0] {
    INIT_NEXT_N,
    INIT_WAIT_T0,
    INIT_TERM,
    INIT_WAIT_SUM,
    INIT_WAIT_T,
    INIT_ACC,
    INIT_DONE
  } init_state_t;

  // one draw as classified by the front end
  typedef struct packed {
    logic [MULT_W-1:0]    mult;
    logic [ROM_IDX_W-1:0] idx;
    logic [STAGE_W-1:0]   stage;
    logic                 wrapped;
  } cud_item_t;

  // configuration write toward the front end
  typedef struct packed {
    logic              we;
    logic [MULT_W-1:0] data;
  } cud_cfg_wr_t;

  function automatic logic [N_W-1:0] cud_prime(input logic [ROM_IDX_W-1:0] idx);
    logic [N_W-1:0] p;
    unique case (idx)
      4'd0:    p = 6'd2;
      4'd1:    p = 6'd3;
      4'd2:    p = 6'd5;
      4'd3:    p = 6'd7;
      4'd4:    p = 6'd11;
      4'd5:    p = 6'd13;
      4'd6:    p = 6'd17;
      4'd7:    p = 6'd19;
      4'd8:    p = 6'd23;
      4'd9:    p = 6'd29;
      4'd10:   p = 6'd31;
      4'd11:   p = 6'd37;
      4'd12:   p = 6'd41;
      4'd13:   p = 6'd43;
      4'd14:   p = 6'd47;
      default: p = 6'd53;
    endcase
    return p;
  endfunction

  function automatic logic [MULT_W-1:0] cud_stage_limit(input logic [STAGE_W-1:0] s);
    logic [MULT_W-1:0] lim;
    unique case (s)
      4'd0:    lim = 31'd2;
      4'd1:    lim = 31'd2;
      4'd2:    lim = 31'd4;
      4'd3:    lim = 31'd15;
      4'd4:    lim = 31'd65;
      4'd5:    lim = 31'd315;
      4'd6:    lim = 31'd1586;
      4'd7:    lim = 31'd8036;
      4'd8:    lim = 31'd40448;
      4'd9:    lim = 31'd200401;
      4'd10:   lim = 31'd972536;
      4'd11:   lim = 31'd4609846;
      4'd12:   lim = 31'd21310545;
      4'd13:   lim = 31'd96017492;
      4'd14:   lim = 31'd421606654;
      default: lim = 31'd1804551131;
    endcase
    return lim;
  endfunction

endpackage

// ===== rtl/core/cud_log_init.sv =====
// log table builder: fills ln(prime) in Q3.61 after reset with a serial divider
module cud_log_init import cud_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ROM_IDX_W-1:0] rd_idx,
  output logic [ROM_W-1:0]     rd_data,
  output logic                 done
);

  init_state_t state_r, state_nxt;

  logic [N_W-1:0]    n_r;
  logic [SLOT_W-1:0] slot_r;
  logic [K_W-1:0]    k_r;
  logic [DIV_W-1:0]  t_r;
  logic [DIV_W-1:0]  sum_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ROM_W-1:0]  rom_r [ROM_DEPTH];

  // serial divider
  logic                 div_busy_r;
  logic                 div_done_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DIV_W-1:0]     div_quo_r;
  logic [DEN_W-1:0]     div_rem_r;
  logic [DEN_W-1:0]     div_den_r;
  logic [DEN_W:0]       rem_shift;
  logic                 rem_ge;
  logic [DEN_W-1:0]     rem_nxt;

  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DEN_W-1:0]     div_divisor;

  logic [Q_W-1:0]   q;
  logic [DEN_W-1:0] qq;
  logic [K_W:0]     odd_k;
  logic [ACC_W-1:0] acc_sum;
  logic [ACC_W:0]   acc_round;
  logic             slot_hit;

  assign q       = {n_r, 1'b0} - Q_W'(1);
  assign qq      = DEN_W'(q) * DEN_W'(q);
  assign odd_k   = {k_r, 1'b1};
  assign acc_sum = acc_r + {sum_r, 1'b0};
  assign acc_round = {1'b0, acc_sum} + (ACC_W+1)'(1);
  assign slot_hit  = (slot_r < SLOT_W'(ROM_DEPTH)) &&
                     (n_r == cud_prime(slot_r[ROM_IDX_W-1:0]));

  assign rem_shift = {div_rem_r, div_quo_r[DIV_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_den_r};
  assign rem_nxt   = rem_ge ? DEN_W'(rem_shift - {1'b0, div_den_r}) : rem_shift[DEN_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      INIT_NEXT_N:   state_nxt = INIT_WAIT_T0;
      INIT_WAIT_T0:  if (div_done_r) state_nxt = INIT_TERM;
      INIT_TERM:     state_nxt = (t_r == '0) ? INIT_ACC : INIT_WAIT_SUM;
      INIT_WAIT_SUM: if (div_done_r) state_nxt = INIT_WAIT_T;
      INIT_WAIT_T:   if (div_done_r) state_nxt = INIT_TERM;
      INIT_ACC:      state_nxt = (n_r == N_W'(LAST_N)) ? INIT_DONE : INIT_NEXT_N;
      INIT_DONE:     state_nxt = INIT_DONE;
      default:       state_nxt = INIT_DONE;
    endcase
  end

  // divider launch per state
  always_comb begin
    div_start    = 1'b0;
    div_dividend = t_r;
    div_divisor  = qq;
    unique case (state_r)
      INIT_NEXT_N: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(1) << (DIV_W - 1);
        div_divisor  = DEN_W'(q);
      end
      INIT_TERM: begin
        div_start   = (t_r != '0);
        div_divisor = DEN_W'(odd_k);
      end
      INIT_WAIT_SUM: begin
        div_start   = div_done_r;
        div_divisor = qq;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      if (div_start) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && (div_cnt_r == DIV_CNT_W'(DIV_W - 1))) begin
        div_busy_r <= 1'b0;
        div_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_quo_r <= div_dividend;
      div_rem_r <= '0;
      div_den_r <= div_divisor;
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      div_quo_r <= {div_quo_r[DIV_W-2:0], rem_ge};
      div_rem_r <= rem_nxt;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= INIT_NEXT_N;
      n_r     <= N_W'(2);
      slot_r  <= '0;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == INIT_ACC) begin
        acc_r <= acc_sum;
        n_r   <= n_r + N_W'(1);
        if (slot_hit) begin
          slot_r <= slot_r + SLOT_W'(1);
        end
      end
    end
  end

  // series datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      INIT_WAIT_T0: if (div_done_r) begin
        t_r   <= div_quo_r;
        sum_r <= '0;
        k_r   <= '0;
      end
      INIT_WAIT_SUM: if (div_done_r) begin
        sum_r <= sum_r + div_quo_r;
      end
      INIT_WAIT_T: if (div_done_r) begin
        t_r <= div_quo_r;
        k_r <= k_r + K_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state_r == INIT_ACC) && slot_hit) begin
      rom_r[slot_r[ROM_IDX_W-1:0]] <= acc_round[ACC_W:1];
    end
  end

  assign rd_data = rom_r[rd_idx];
  assign done    = (state_r == INIT_DONE);

endmodule

// ===== rtl/core/cud_front.sv =====
// front end: takes draw requests, steps the counters and queues each draw
module cud_front import cud_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              init_done,
  input  cud_cfg_wr_t       cfg_wr,
  output logic [MULT_W-1:0] start_mult,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_draw_request,
  input  logic              q_full,
  output logic              push,
  output cud_item_t         push_item
);

  logic [MULT_W-1:0]    start_r;
  logic [MULT_W-1:0]    mult_r, mult_nxt;
  logic [ROM_IDX_W-1:0] prime_r, prime_nxt;
  logic [STAGE_W-1:0]   stage_r, stage_nxt;

  logic               accept;
  logic               j_ge;
  logic [MULT_W:0]    next_m;
  logic               limit_hit;
  logic [STAGE_W:0]   stage_inc;
  logic               stage_wrap;

  assign in_stall = !init_done || q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && in_draw_request;

  assign j_ge       = prime_r >= stage_r;
  assign next_m     = j_ge ? ({1'b0, mult_r} + (MULT_W+1)'(1)) : {1'b0, mult_r};
  assign limit_hit  = next_m >= {1'b0, cud_stage_limit(stage_r)};
  assign stage_inc  = {1'b0, stage_r} + (STAGE_W+1)'(1);
  assign stage_wrap = stage_inc >= (STAGE_W+1)'(STAGES);

  always_comb begin
    prime_nxt = j_ge ? '0 : prime_r + ROM_IDX_W'(1);
    mult_nxt  = limit_hit ? MULT_W'(1) : next_m[MULT_W-1:0];
    stage_nxt = stage_r;
    if (limit_hit) begin
      stage_nxt = stage_wrap ? '0 : stage_inc[STAGE_W-1:0];
    end
  end

  always_comb begin
    push_item.mult    = mult_r;
    push_item.idx     = prime_r;
    push_item.stage   = stage_r;
    push_item.wrapped = limit_hit && stage_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= MULT_W'(1);
      mult_r  <= MULT_W'(1);
      prime_r <= '0;
      stage_r <= '0;
    end else if (cfg_wr.we) begin
      start_r <= cfg_wr.data;
      mult_r  <= cfg_wr.data;
    end else if (push) begin
      mult_r  <= mult_nxt;
      prime_r <= prime_nxt;
      stage_r <= stage_nxt;
    end
  end

  assign start_mult = start_r;

endmodule

// ===== rtl/core/cud_queue.sv =====
// short queue of classified draws between front and back end
module cud_queue import cud_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cud_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output cud_item_t pop_item
);

  cud_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/cud_back.sv =====
// back end: multiplier by log table entry, fraction extract, output register
module cud_back import cud_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  cud_item_t            q_item,
  output logic                 q_pop,
  output logic [ROM_IDX_W-1:0] rom_idx,
  input  logic [ROM_W-1:0]     rom_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FRAC_W-1:0]    out_fraction,
  output logic [STAGE_W-1:0]   out_stage,
  output logic                 out_wrapped
);

  logic                  a_valid_r;
  logic [PLO_W-1:0]      a_plo_r;
  logic [HI_W-1:0]       a_phi_r;
  logic [STAGE_W-1:0]    a_stage_r;
  logic                  a_wrap_r;

  logic                  out_valid_r;
  logic [FRAC_W-1:0]     out_fraction_r;
  logic [STAGE_W-1:0]    out_stage_r;
  logic                  out_wrapped_r;

  logic                  out_free;
  logic                  a_free;
  logic [PLO_W-1:0]      plo;
  logic [HI_W-1:0]       phi;
  logic [LOG_FRAC-1:0]   frac61;
  logic [LOG_FRAC-1:0]   frac_shifted;

  assign out_free = !out_valid_r || !out_stall;
  assign a_free   = !a_valid_r || out_free;
  assign q_pop    = !q_empty && a_free;
  assign rom_idx  = q_item.idx;

  // low 61 bits of mult * entry from two partial products
  assign plo = PLO_W'(q_item.mult) * PLO_W'(rom_data[LO_W-1:0]);
  assign phi = q_item.mult[HI_W-1:0] * rom_data[LOG_FRAC-1:LO_W];

  assign frac61       = a_plo_r[LOG_FRAC-1:0] + {a_phi_r, {LO_W{1'b0}}};
  assign frac_shifted = frac61 >> FRAC_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_r <= q_pop;
      end
      if (out_free) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_plo_r   <= plo;
      a_phi_r   <= phi;
      a_stage_r <= q_item.stage;
      a_wrap_r  <= q_item.wrapped;
    end
    if (out_free && a_valid_r) begin
      out_fraction_r <= frac_shifted[FRAC_W-1:0];
      out_stage_r    <= a_stage_r;
      out_wrapped_r  <= a_wrap_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_fraction = out_fraction_r;
  assign out_stage    = out_stage_r;
  assign out_wrapped  = out_wrapped_r;

endmodule

// ===== rtl/core/cud_quasi_random_generator_unit.sv =====
// top level: quasi-random generator from the log-prime sequence
// path: an accepted draw passes through the queue, the product register and the output register to out_*
// throughput: one draw per cycle while in_stall is low, set by the counter step in the front end
// reset: counters to multiplier 1, prime 0, stage 0; then the log table is
//   built by a one-bit-a-cycle divider with in_stall high; register writes are taken
module cud_quasi_random_generator_unit import cud_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // draw requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_draw_request,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FRAC_W-1:0]    out_fraction,
  output logic [STAGE_W-1:0]   out_stage,
  output logic                 out_wrapped,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic                 init_done;
  logic [ROM_IDX_W-1:0] rom_idx;
  logic [ROM_W-1:0]     rom_data;

  cud_cfg_wr_t          cfg_wr;
  logic [MULT_W-1:0]    start_mult;
  logic [REG_IDX_W-1:0] reg_idx;

  logic                 push;
  cud_item_t            push_item;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  cud_item_t            q_item;

  // register decode: one register at byte addresses 0 to 3 (paddr[2] low), writes with paddr[2] high dropped
  assign pready      = 1'b1;
  assign reg_idx     = paddr[2];
  assign cfg_wr.we   = psel && penable && pwrite && pready && (reg_idx == REG_START);
  assign cfg_wr.data = pwdata[MULT_W-1:0];
  assign prdata      = (reg_idx == REG_START) ? {1'b0, start_mult} : '0;

  // ln(prime) table, filled once after reset
  cud_log_init u_log_init (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rom_idx),
    .rd_data (rom_data),
    .done    (init_done)
  );

  // counter state machine; each draw leaves with its multiplier, prime and stage
  cud_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .init_done       (init_done),
    .cfg_wr          (cfg_wr),
    .start_mult      (start_mult),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_draw_request (in_draw_request),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  // decouples the counter step from output backpressure
  cud_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_item)
  );

  // two-stage multiply and fraction extract with output register
  cud_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .rom_idx      (rom_idx),
    .rom_data     (rom_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_fraction (out_fraction),
    .out_stage    (out_stage),
    .out_wrapped  (out_wrapped)
  );

endmodule
